### hw/rtl/sgb_pkg.sv
// ----------------------------------------------------------------------------
// sgb_pkg
// Shared types and constants for the scatter grid binning block.
// ----------------------------------------------------------------------------
package sgb_pkg;

  localparam int PT_DEPTH  = 4096;
  localparam int PT_AW     = 12;
  localparam int CNT_W     = 13;
  localparam int CELL_AW   = 10;
  localparam int SUM_W     = 44;
  localparam int SIDE_W    = 6;
  localparam int GRID_LIM  = 500;
  localparam int SIDE_MAX  = 32;
  localparam int ONE_Q16   = 65536;
  localparam int DIV_NW    = 44;
  localparam int DIV_DW    = 33;

  // operation codes carried in the input tuser
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  typedef struct packed {
    logic               bad;
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } point_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } cell_t;

endpackage

### hw/rtl/scatter_grid_binning_average.sv
// ----------------------------------------------------------------------------
// scatter_grid_binning_average
// Loads points, bins them onto a square grid of cell averages, reads cells.
// ----------------------------------------------------------------------------
// A load request writes the point store; up to 4096 points are kept,
// further loads are dropped and raise the overflow flag. A finish
// request first clears the 1024 cells, then walks the stored points
// twice through the point memory port: once for the bounds, then, after
// the square root of N/4, once for binning, where each valid point runs
// the 44-step serial divider twice and a bad point is skipped. A read
// request returns the cell, its average formed by the same divider when
// the cell holds points. One request is worked at a time; the result
// register lets the next request in while a result waits.
module scatter_grid_binning_average (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // x_coord[31:0], y_coord[63:32], z_value[95:64], cell_index[105:96], zero pad
  input  logic [111:0] s_tdata,
  // op[1:0], z_invalid[2]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // grid_side[5:0], cell_average[37:6], zero pad
  output logic [39:0]  m_tdata,
  // cell_empty[0], overflow[1]
  output logic [1:0]   m_tuser
);
  import sgb_pkg::*;

  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_CLR    = 14'b00000000000010,
    ST_BRD    = 14'b00000000000100,
    ST_BUPD   = 14'b00000000001000,
    ST_SQRT   = 14'b00000000010000,
    ST_PRD    = 14'b00000000100000,
    ST_PMUL   = 14'b00000001000000,
    ST_PDX    = 14'b00000010000000,
    ST_PDY    = 14'b00000100000000,
    ST_CIDX   = 14'b00001000000000,
    ST_CUPD   = 14'b00010000000000,
    ST_RDWAIT = 14'b00100000000000,
    ST_ADIV   = 14'b01000000000000,
    ST_OUT    = 14'b10000000000000
  } state_t;

  state_t state;

  logic [1:0]         in_op;
  logic [CELL_AW-1:0] in_idx;
  point_t             in_pt;

  logic [CNT_W-1:0]   count;
  logic               drop;
  logic [SIDE_W-1:0]  side;
  logic [SIDE_W-1:0]  sq;
  logic [CNT_W-1:0]   pidx;
  logic [CELL_AW-1:0] clr_cnt;
  logic               any;
  logic signed [31:0] min_x, max_x, min_y, max_y;
  logic [DIV_DW-1:0]  range_x, range_y;
  logic [DIV_DW-1:0]  diff_x_rng, diff_y_rng;
  logic [DIV_NW-1:0]  prod_x, prod_y;
  logic signed [31:0] z_hold;
  logic [4:0]         col, row;
  logic [CELL_AW-1:0] cidx;
  logic               in_grid;
  logic               neg;
  logic [31:0]        res_avg;
  logic               res_empty;
  logic [DIV_NW-1:0]  avg_num;
  logic [DIV_DW-1:0]  avg_den;

  point_t             pt_rd;
  logic               pt_we;
  cell_t              cell_rd;
  cell_t              cell_wdata;
  logic               cell_we;
  logic [CELL_AW-1:0] cell_waddr;
  logic [CELL_AW-1:0] cell_raddr;

  logic               div_go;
  logic               div_go_next;
  logic [DIV_NW-1:0]  div_num;
  logic [DIV_DW-1:0]  div_den;
  logic               div_done;
  logic [DIV_NW-1:0]  div_q;

  logic [SIDE_W-1:0]  side_m1;
  logic [6:0]         sq_p1;
  logic [13:0]        sq_p1_sq;
  logic [10:0]        quarter;
  logic [11:0]        side_sq;
  logic [10:0]        cidx_full;
  logic [DIV_DW-1:0]  dx, dy;
  logic [SUM_W-1:0]   sum_mag;
  logic [4:0]         q_clamp;

  // request fields
  assign in_op    = s_tuser[1:0];
  assign in_pt.x  = s_tdata[31:0];
  assign in_pt.y  = s_tdata[63:32];
  assign in_pt.z  = s_tdata[95:64];
  assign in_pt.bad = s_tuser[2];
  assign in_idx   = s_tdata[105:96];

  assign s_tready = (state == ST_IDLE);

  // small arithmetic helpers
  assign side_m1  = side - 6'd1;
  assign sq_p1    = {1'b0, sq} + 7'd1;
  assign sq_p1_sq = 14'(sq_p1) * 14'(sq_p1);
  assign quarter  = count[CNT_W-1:2];
  assign side_sq  = 12'(side) * 12'(side);
  assign cidx_full = 11'(row) * 11'(side) + 11'(col);
  assign dx = DIV_DW'({pt_rd.x[31], pt_rd.x} - {min_x[31], min_x});
  assign dy = DIV_DW'({pt_rd.y[31], pt_rd.y} - {min_y[31], min_y});
  assign diff_x_rng = DIV_DW'({max_x[31], max_x} - {min_x[31], min_x});
  assign diff_y_rng = DIV_DW'({max_y[31], max_y} - {min_y[31], min_y});
  assign sum_mag  = cell_rd.sum[SUM_W-1] ? SUM_W'(-cell_rd.sum) : cell_rd.sum;
  assign q_clamp  = (div_q > DIV_NW'(side_m1)) ? side_m1[4:0] : div_q[4:0];

  // memory port selection
  assign pt_we      = s_tvalid && s_tready && (in_op == OP_LOAD)
                      && (count != CNT_W'(PT_DEPTH));
  assign cell_raddr = (state == ST_IDLE) ? in_idx : cidx_full[CELL_AW-1:0];
  assign cell_we    = (state == ST_CLR) || (state == ST_CUPD);
  assign cell_waddr = (state == ST_CLR) ? clr_cnt : cidx;
  always_comb begin
    if (state == ST_CLR) begin
      cell_wdata = '0;
    end else begin
      cell_wdata.sum = cell_rd.sum + SUM_W'(z_hold);
      cell_wdata.cnt = cell_rd.cnt + CNT_W'(1);
    end
  end

  // divider operand selection
  always_comb begin
    case (state)
      ST_PDX: begin
        div_num = prod_x;
        div_den = range_x;
      end
      ST_PDY: begin
        div_num = prod_y;
        div_den = range_y;
      end
      default: begin
        div_num = avg_num;
        div_den = avg_den;
      end
    endcase
  end

  // divider start, registered together with its operands
  always_comb begin
    case (state)
      ST_PMUL: begin
        div_go_next = !pt_rd.bad;
      end
      ST_PDX: begin
        div_go_next = div_done;
      end
      ST_RDWAIT: begin
        div_go_next = in_grid && (cell_rd.cnt != '0);
      end
      default: begin
        div_go_next = 1'b0;
      end
    endcase
  end

  sgb_point_mem u_pts (
    .clk   (clk),
    .we    (pt_we),
    .waddr (count[PT_AW-1:0]),
    .wdata (in_pt),
    .raddr (pidx[PT_AW-1:0]),
    .rdata (pt_rd)
  );

  sgb_cell_mem u_cells (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rd)
  );

  sgb_div u_div (
    .clk   (clk),
    .rst   (rst),
    .go    (div_go),
    .numer (div_num),
    .denom (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      drop     <= 1'b0;
      side     <= '0;
      div_go   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      div_go <= div_go_next;
      if (m_tvalid && m_tready && (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            case (in_op)
              OP_LOAD: begin
                if (count != CNT_W'(PT_DEPTH)) begin
                  count <= count + CNT_W'(1);
                end else begin
                  drop <= 1'b1;
                end
              end
              OP_FINISH: begin
                clr_cnt <= '0;
                state   <= ST_CLR;
              end
              OP_READ: begin
                in_grid <= 12'(in_idx) < side_sq;
                state   <= ST_RDWAIT;
              end
              default: begin
              end
            endcase
          end
        end
        ST_CLR: begin
          clr_cnt <= clr_cnt + CELL_AW'(1);
          if (clr_cnt == '1) begin
            pidx  <= '0;
            any   <= 1'b0;
            min_x <= '0;
            max_x <= '0;
            min_y <= '0;
            max_y <= '0;
            state <= ST_BRD;
          end
        end
        ST_BRD: begin
          if (pidx == count) begin
            sq    <= '0;
            state <= ST_SQRT;
          end else begin
            state <= ST_BUPD;
          end
        end
        ST_BUPD: begin
          if (!pt_rd.bad) begin
            any <= 1'b1;
            if (!any || pt_rd.x < min_x) min_x <= pt_rd.x;
            if (!any || pt_rd.x > max_x) max_x <= pt_rd.x;
            if (!any || pt_rd.y < min_y) min_y <= pt_rd.y;
            if (!any || pt_rd.y > max_y) max_y <= pt_rd.y;
          end
          pidx  <= pidx + CNT_W'(1);
          state <= ST_BRD;
        end
        ST_SQRT: begin
          range_x <= (diff_x_rng == '0) ? DIV_DW'(ONE_Q16) : diff_x_rng;
          range_y <= (diff_y_rng == '0) ? DIV_DW'(ONE_Q16) : diff_y_rng;
          if (sq_p1_sq <= 14'(quarter)) begin
            sq <= sq + 6'd1;
          end else begin
            // side is min(limit, 32, root)
            if (32'(sq) > GRID_LIM) begin
              side <= SIDE_W'(GRID_LIM);
            end else if (32'(sq) > SIDE_MAX) begin
              side <= SIDE_W'(SIDE_MAX);
            end else begin
              side <= sq;
            end
            pidx      <= '0;
            res_avg   <= '0;
            res_empty <= 1'b0;
            state     <= (sq == '0) ? ST_OUT : ST_PRD;
          end
        end
        ST_PRD: begin
          state <= (pidx == count) ? ST_OUT : ST_PMUL;
        end
        ST_PMUL: begin
          if (pt_rd.bad) begin
            pidx  <= pidx + CNT_W'(1);
            state <= ST_PRD;
          end else begin
            prod_x <= DIV_NW'(dx) * DIV_NW'(side_m1);
            prod_y <= DIV_NW'(dy) * DIV_NW'(side_m1);
            z_hold <= pt_rd.z;
            state  <= ST_PDX;
          end
        end
        ST_PDX: begin
          if (div_done) begin
            col    <= q_clamp;
            state  <= ST_PDY;
          end
        end
        ST_PDY: begin
          if (div_done) begin
            row   <= q_clamp;
            state <= ST_CIDX;
          end
        end
        ST_CIDX: begin
          cidx  <= cidx_full[CELL_AW-1:0];
          state <= ST_CUPD;
        end
        ST_CUPD: begin
          pidx  <= pidx + CNT_W'(1);
          state <= ST_PRD;
        end
        ST_RDWAIT: begin
          // hold the cell operands, the read port moves on
          if (in_grid && cell_rd.cnt != '0) begin
            neg     <= cell_rd.sum[SUM_W-1];
            avg_num <= sum_mag;
            avg_den <= DIV_DW'(cell_rd.cnt);
            state   <= ST_ADIV;
          end else begin
            res_avg   <= '0;
            res_empty <= 1'b1;
            state     <= ST_OUT;
          end
        end
        ST_ADIV: begin
          if (div_done) begin
            res_avg   <= neg ? 32'(-div_q) : div_q[31:0];
            res_empty <= 1'b0;
            state     <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, res_avg, side};
            m_tuser  <= {drop, res_empty};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/sgb_point_mem.sv
// ----------------------------------------------------------------------------
// sgb_point_mem
// Point store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sgb_point_mem (
  input  logic                   clk,
  input  logic                   we,
  input  logic [sgb_pkg::PT_AW-1:0] waddr,
  input  sgb_pkg::point_t        wdata,
  input  logic [sgb_pkg::PT_AW-1:0] raddr,
  output sgb_pkg::point_t        rdata
);
  import sgb_pkg::*;

  point_t mem [PT_DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/sgb_cell_mem.sv
// ----------------------------------------------------------------------------
// sgb_cell_mem
// Cell sum and count store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sgb_cell_mem (
  input  logic                        clk,
  input  logic                        we,
  input  logic [sgb_pkg::CELL_AW-1:0] waddr,
  input  sgb_pkg::cell_t              wdata,
  input  logic [sgb_pkg::CELL_AW-1:0] raddr,
  output sgb_pkg::cell_t              rdata
);
  import sgb_pkg::*;

  cell_t mem [2**CELL_AW];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/sgb_div.sv
// ----------------------------------------------------------------------------
// sgb_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sgb_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [sgb_pkg::DIV_NW-1:0] numer,
  input  logic [sgb_pkg::DIV_DW-1:0] denom,
  output logic                       done,
  output logic [sgb_pkg::DIV_NW-1:0] quot
);
  import sgb_pkg::*;

  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] den;
  logic [5:0]        cnt;
  logic              busy;
  logic [DIV_DW:0]   trial;
  logic              fits;

  // shift in the next numerator bit and try a subtract
  assign trial = {rem, quot[DIV_NW-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= 6'(DIV_NW);
        rem  <= '0;
        den  <= denom;
        quot <= numer;
      end else if (busy) begin
        rem  <= fits ? DIV_DW'(trial - {1'b0, den}) : trial[DIV_DW-1:0];
        quot <= {quot[DIV_NW-2:0], fits};
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream testbench for scatter_grid_binning_average: loads, finishes and
// reads go in through a driver fed from a request queue. A cycle-free
// predictor works out each finish and read result, and a monitor compares
// every result field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sgb_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 450000;
  localparam int TAIL_CYCLES = 200;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               bad;
    logic [9:0]         idx;
  } request_t;

  typedef struct {
    logic [5:0]  side;
    logic [31:0] avg;
    logic        empty;
    logic        ovf;
  } cell_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [39:0]  m_tdata;
  logic [1:0]   m_tuser;

  scatter_grid_binning_average dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  // predicted block state
  logic signed [31:0] pt_x [PT_DEPTH];
  logic signed [31:0] pt_y [PT_DEPTH];
  logic signed [31:0] pt_z [PT_DEPTH];
  logic               pt_bad [PT_DEPTH];
  int                 pt_count = 0;
  logic [SUM_W-1:0]   grid_sum [1024];
  logic [CNT_W-1:0]   grid_cnt [1024];
  int                 grid_side = 0;
  logic               dropped = 1'b0;

  request_t     pending_q [$];
  cell_result_t cell_result_q [$];
  request_t     cur;
  logic         taken = 1'b0;
  int           send_gap = 0;
  int           stall = 0;
  bit           quiet = 0;
  int           fails = 0;
  int           idle_cycles = 0;

  function automatic int cell_of(logic signed [31:0] v, logic signed [31:0] lo,
                                 logic signed [31:0] hi, int side);
    longint diff, span, idx;
    diff = longint'(v) - longint'(lo);
    span = longint'(hi) - longint'(lo);
    if (span == 0) span = ONE_Q16;
    idx = diff * (side - 1) / span;
    if (idx > side - 1) idx = side - 1;
    return int'(idx);
  endfunction

  // rebuild bounds, side and cell totals from all stored points
  task automatic bin_points();
    logic signed [31:0] lo_x, hi_x, lo_y, hi_y;
    bit any;
    int q, s, c;
    lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
    any = 0;
    for (int k = 0; k < 1024; k++) begin
      grid_sum[k] = '0;
      grid_cnt[k] = '0;
    end
    for (int i = 0; i < pt_count; i++) begin
      if (!pt_bad[i]) begin
        if (!any) begin
          lo_x = pt_x[i]; hi_x = pt_x[i]; lo_y = pt_y[i]; hi_y = pt_y[i];
          any = 1;
        end else begin
          if (pt_x[i] < lo_x) lo_x = pt_x[i];
          if (pt_x[i] > hi_x) hi_x = pt_x[i];
          if (pt_y[i] < lo_y) lo_y = pt_y[i];
          if (pt_y[i] > hi_y) hi_y = pt_y[i];
        end
      end
    end
    q = pt_count / 4;
    s = 0;
    while ((s + 1) * (s + 1) <= q) s++;
    if (s > GRID_LIM) s = GRID_LIM;
    if (s > SIDE_MAX) s = SIDE_MAX;
    grid_side = s;
    if (s == 0) return;
    for (int i = 0; i < pt_count; i++) begin
      if (!pt_bad[i]) begin
        c = (cell_of(pt_y[i], lo_y, hi_y, s) * s + cell_of(pt_x[i], lo_x, hi_x, s)) & 1023;
        grid_sum[c] = grid_sum[c] + {{(SUM_W-32){pt_z[i][31]}}, pt_z[i]};
        grid_cnt[c] = grid_cnt[c] + 1'b1;
      end
    end
  endtask

  // update state for one accepted request and queue the result of a finish or read
  task automatic predict(request_t r);
    cell_result_t e;
    longint total;
    e.side = grid_side[5:0];
    e.avg = '0;
    e.empty = 1'b1;
    e.ovf = dropped;
    case (r.op)
      OP_LOAD: begin
        if (pt_count < PT_DEPTH) begin
          pt_x[pt_count] = r.x; pt_y[pt_count] = r.y;
          pt_z[pt_count] = r.z; pt_bad[pt_count] = r.bad;
          pt_count++;
        end else begin
          dropped = 1'b1;
        end
      end
      OP_FINISH: begin
        bin_points();
        e.side = grid_side[5:0];
        e.empty = 1'b0;
        e.ovf = dropped;
        cell_result_q = {cell_result_q, e};
      end
      OP_READ: begin
        if (int'(r.idx) < grid_side * grid_side && grid_cnt[r.idx] != 0) begin
          total = longint'($signed(grid_sum[r.idx]));
          total = total / longint'(grid_cnt[r.idx]);
          e.avg = total[31:0];
          e.empty = 1'b0;
        end
        cell_result_q = {cell_result_q, e};
      end
      default: ;
    endcase
  endtask

  task automatic push_req(logic [1:0] op, logic [31:0] x, logic [31:0] y,
                          logic [31:0] z, logic bad, logic [9:0] idx);
    request_t r;
    r.op = op; r.x = x; r.y = y; r.z = z; r.bad = bad; r.idx = idx;
    pending_q = {pending_q, r};
  endtask

  // random point: mostly a cluster with duplicates, sometimes any value
  task automatic push_rand_load(int bad_pct);
    logic [31:0] x, y, z;
    logic bad;
    bad = ($urandom_range(0, 99) < bad_pct);
    z = $urandom;
    case ($urandom_range(0, 3))
      0: begin x = $urandom; y = $urandom; end
      1: begin x = 32'h0001_0000; y = $urandom_range(0, 3) << 16; end
      default: begin
        x = $urandom_range(0, 20000) - 10000;
        y = $urandom_range(0, 20000) - 10000;
        z = $urandom_range(0, 2000000) - 1000000;
      end
    endcase
    push_req(OP_LOAD, x, y, z, bad, 10'($urandom));
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      taken <= 1'b1;
      predict(cur);
    end else if (!s_tvalid) begin
      taken <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst && (!s_tvalid || taken)) begin
      taken <= 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        cur = pending_q.pop_front();
        s_tdata <= {6'b0, cur.idx, cur.z, cur.y, cur.x};
        s_tuser <= {cur.bad, cur.op};
        s_tvalid <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 12);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall > 0) begin
      stall--;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      stall = $urandom_range(1, 12);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    cell_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (cell_result_q.size() == 0) begin
        $display("%0t: unexpected result side=%0d avg=%h empty=%b ovf=%b", $time,
                 m_tdata[5:0], m_tdata[37:6], m_tuser[0], m_tuser[1]);
        fails++;
      end else begin
        e = cell_result_q.pop_front();
        if (m_tdata[5:0] !== e.side) begin
          $display("%0t: grid_side expected %0d actual %0d", $time, e.side, m_tdata[5:0]);
          fails++;
        end
        if (m_tdata[37:6] !== e.avg) begin
          $display("%0t: cell_average expected %h actual %h", $time, e.avg, m_tdata[37:6]);
          fails++;
        end
        if (m_tuser[0] !== e.empty) begin
          $display("%0t: cell_empty expected %b actual %b", $time, e.empty, m_tuser[0]);
          fails++;
        end
        if (m_tuser[1] !== e.ovf) begin
          $display("%0t: overflow expected %b actual %b", $time, e.ovf, m_tuser[1]);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** scatter_grid_binning_average: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int loads, reads;
    // directed: reads before any grid, unused op, finish with no points
    push_req(OP_READ, 0, 0, 0, 0, 10'd0);
    push_req(OP_READ, 0, 0, 0, 0, 10'h3FF);
    push_req(OP_UNUSED, '1, '1, '1, 1, '1);
    push_req(OP_FINISH, 0, 0, 0, 0, 0);
    // fewer than four points, extreme coordinates
    push_req(OP_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
    push_req(OP_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, 0);
    push_req(OP_LOAD, 32'h0, 32'h0, 32'hFFFF_FFFF, 0, 0);
    push_req(OP_FINISH, 0, 0, 0, 0, 0);
    push_req(OP_READ, 0, 0, 0, 0, 10'd0);
    // not-a-number point counts toward the side but not the sums
    push_req(OP_LOAD, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 1, 0);
    push_req(OP_FINISH, 0, 0, 0, 0, 0);
    push_req(OP_READ, 0, 0, 0, 0, 10'd0);
    push_req(OP_READ, 0, 0, 0, 0, 10'd1);
    // repeated finish on the same set
    push_req(OP_FINISH, 0, 0, 0, 0, 0);
    // zero range in both axes, extreme values
    for (int i = 0; i < 8; i++)
      push_req(OP_LOAD, 32'h0003_0000, 32'hFFFF_0000,
               (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000, 0, 0);
    push_req(OP_FINISH, 0, 0, 0, 0, 0);
    for (int i = 0; i < 4; i++) push_req(OP_READ, 0, 0, 0, 0, i[9:0]);

    // random phases of loads, a finish, then reads
    while (pending_q.size() < 950) begin
      loads = $urandom_range(10, 60);
      for (int i = 0; i < loads; i++) begin
        if ($urandom_range(0, 9) == 0) push_req(OP_UNUSED, $urandom, $urandom,
                                                $urandom, 1'($urandom), 10'($urandom));
        push_rand_load(25);
      end
      push_req(OP_FINISH, 0, 0, 0, 0, 0);
      reads = $urandom_range(5, 20);
      for (int i = 0; i < reads; i++)
        push_req(OP_READ, $urandom, $urandom, $urandom, 1'($urandom),
                 ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, 144)));
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() > 40) @(posedge clk);
    quiet = 1;
    while (pending_q.size() > 0 || (s_tvalid && !taken) || cell_result_q.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (cell_result_q.size() != 0) fails++;
    if (fails == 0) begin
      $display("** scatter_grid_binning_average: PASSED **");
    end else begin
      $display("** scatter_grid_binning_average: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/sgb_pkg.sv
hw/rtl/sgb_point_mem.sv
hw/rtl/sgb_cell_mem.sv
hw/rtl/sgb_div.sv
hw/rtl/scatter_grid_binning_average.sv
sim/tb.sv
